### design/kre_pkg.sv
// ----------------------------------------------------------------------------
// kre_pkg
// Shared types and constants of the keyframe rate envelope.
// ----------------------------------------------------------------------------
package kre_pkg;

	localparam int MAX_POINTS = 8;
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam logic [32:0] MATCH_TOLERANCE = 33'd66;

	localparam logic [1:0] REG_LOOP_ENABLE = 2'd0;
	localparam logic [1:0] REG_LOOP_LENGTH = 2'd1;
	localparam logic [1:0] REG_POINT_COUNT = 2'd2;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [16:0] delta_time;
		logic [2:0]  point_index;
		logic [31:0] point_time;
		logic [15:0] point_rate;
	} req_t;

	typedef struct packed {
		logic [15:0] emit_count;
		logic [15:0] current_rate;
		logic [31:0] play_position;
	} rsp_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [31:0] data;
	} cfg_t;

	typedef enum logic [3:0] {
		S_IDLE, S_ADVANCE, S_READ, S_CHECK, S_MUL, S_DIV, S_SEG_DONE,
		S_EDGE_READ, S_EDGE, S_EMIT_MUL, S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic write_key;
		logic advance;
		logic read_seg;
		logic check;
		logic mul;
		logic div_start;
		logic div_step;
		logic seg_take;
		logic edge_read;
		logic edge_apply;
		logic emit_mul;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_write;
		logic last_seg;
		logic empty;
		logic seg_match;
		logic seg_direct;
		logic div_done;
	} sts_t;

endpackage

### design/kre_if.sv
// ----------------------------------------------------------------------------
// kre_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface kre_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### design/kre_ctrl.sv
// ----------------------------------------------------------------------------
// kre_ctrl
// Sequencer: segment walk, serial divide, emit, result handoff.
// ----------------------------------------------------------------------------
module kre_ctrl import kre_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_ADVANCE;
				end
			end
			S_ADVANCE: begin
				if (sts.is_write) begin
					cmd.write_key = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.advance = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: begin
				if (sts.empty || sts.last_seg) begin
					state_d = S_EDGE_READ;
				end else begin
					cmd.read_seg = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (!sts.seg_match)
					state_d = S_SEG_DONE;
				else if (sts.seg_direct)
					state_d = S_SEG_DONE;
				else
					state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DIV;
				cmd.div_start = 1'b1;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					cmd.seg_take = 1'b1;
					state_d = S_SEG_DONE;
				end
			end
			S_SEG_DONE: state_d = S_READ;
			S_EDGE_READ: begin
				cmd.edge_read = 1'b1;
				state_d = S_EDGE;
			end
			S_EDGE: begin
				cmd.edge_apply = 1'b1;
				state_d = S_EMIT_MUL;
			end
			S_EMIT_MUL: begin
				cmd.emit_mul = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	ap_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE) else $error("ready outside idle");
	ap_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.seg_take |-> state_q == S_DIV) else $error("take outside divide");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

### design/kre_dpath.sv
// ----------------------------------------------------------------------------
// kre_dpath
// Keyframe table, play clock, segment interpolation and serial divider.
// ----------------------------------------------------------------------------
module kre_dpath import kre_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  logic cfg_we,
	input  cfg_t cfg,
	input  cmd_t cmd,
	output sts_t sts,
	output rsp_t rsp
);
	logic                   loop_enable_q;
	logic [31:0]            loop_length_q;
	logic [3:0]             point_count_q;
	logic [31:0]            play_time_q;
	logic [15:0]            held_rate_q, rate_q;
	req_t                   req_q;
	logic [31:0]            key_time_q [MAX_POINTS];
	logic [15:0]            key_rate_q [MAX_POINTS];
	logic [IDX_W:0]         seg_q, n;
	logic [31:0]            t0_q, t1_q;
	logic [15:0]            r0_q, r1_q;
	logic [31:0]            e_time_q, f_time_q;
	logic [15:0]            e_rate_q, f_rate_q;
	logic                   neg_q;
	logic [32:0]            den_q;
	logic [48:0]            num_q;
	logic signed [50:0]     total_q;
	logic [49:0]            rem_q, quo_q;
	logic [5:0]             cnt_q;
	logic [32:0]            lo_bound, hi_bound;
	logic [32:0]            dt_s, dr_s;
	logic signed [33:0]     dt_sign;
	logic signed [17:0]     dr_sign;
	logic                   tdn, rdn;
	logic [32:0]            sum;
	logic [31:0]            adv;
	logic [32:0]            prod_q;
	logic [50:0]            trial;
	logic [15:0]            emit_q;
	rsp_t                   rsp_q;

	always_comb begin
		n = (point_count_q > 4'(MAX_POINTS)) ? (IDX_W+1)'(MAX_POINTS)
			: (IDX_W+1)'(point_count_q);
		sum = {1'b0, play_time_q} + {16'd0, req_q.delta_time};
		adv = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		if (loop_enable_q && loop_length_q < adv)
			adv = '0;
		lo_bound = {1'b0, play_time_q} + MATCH_TOLERANCE;
		hi_bound = {1'b0, t1_q} + MATCH_TOLERANCE;
		dt_sign = $signed({2'b0, t1_q}) - $signed({2'b0, t0_q});
		dr_sign = $signed({2'b0, r1_q}) - $signed({2'b0, r0_q});
		tdn = dt_sign < 0;
		rdn = dr_sign < 0;
		dt_s = tdn ? 33'(-dt_sign) : 33'(dt_sign);
		dr_s = rdn ? 33'(-dr_sign) : 33'(dr_sign);
		trial = {rem_q[48:0], quo_q[49]} - {18'd0, den_q};
		sts.is_write = req_q.operation == OP_WRITE;
		sts.empty = n == '0;
		sts.last_seg = (seg_q + 1'b1) >= n;
		sts.seg_match = (lo_bound > {1'b0, t0_q}) && ({1'b0, play_time_q} < hi_bound);
		sts.seg_direct = dt_sign == 0;
		sts.div_done = cnt_q == 6'd51;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_enable_q <= 1'b0;
			loop_length_q <= '0;
			point_count_q <= '0;
			play_time_q   <= '0;
			held_rate_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg.index)
					REG_LOOP_ENABLE: loop_enable_q <= cfg.data[0];
					REG_LOOP_LENGTH: loop_length_q <= cfg.data;
					REG_POINT_COUNT: point_count_q <= cfg.data[3:0];
					default: ;
				endcase
			end
			if (cmd.advance)
				play_time_q <= adv;
			if (cmd.edge_apply) begin
				if (play_time_q < f_time_q)
					held_rate_q <= f_rate_q;
				else if (play_time_q > e_time_q)
					held_rate_q <= e_rate_q;
				else
					held_rate_q <= rate_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			req_q <= req;
		if (cmd.write_key) begin
			key_time_q[req_q.point_index[IDX_W-1:0]] <= req_q.point_time;
			key_rate_q[req_q.point_index[IDX_W-1:0]] <= req_q.point_rate;
		end
		if (cmd.advance) begin
			seg_q  <= '0;
			rate_q <= held_rate_q;
		end
		if (cmd.read_seg) begin
			t0_q <= key_time_q[seg_q[IDX_W-1:0]];
			r0_q <= key_rate_q[seg_q[IDX_W-1:0]];
			t1_q <= key_time_q[IDX_W'(seg_q + 1'b1)];
			r1_q <= key_rate_q[IDX_W'(seg_q + 1'b1)];
		end
		if (cmd.check) begin
			seg_q <= seg_q + 1'b1;
			if (sts.seg_match && sts.seg_direct)
				rate_q <= r0_q;
			den_q <= dt_s;
			neg_q <= tdn ^ rdn;
			num_q <= 49'(dr_s[16:0]) * 49'(1);
			prod_q <= 33'({1'b0, play_time_q} - {1'b0, t0_q});
		end
		if (cmd.mul) begin
			// r0 times |dt|, plus signed (t - t0) times |dr| with the sign of span and slope
			total_q <= $signed({2'b0, 49'(r0_q) * 49'(den_q)}) +
				(neg_q ? -$signed(51'($signed(prod_q)) * $signed({34'd0, num_q[16:0]}))
				: $signed(51'($signed(prod_q)) * $signed({34'd0, num_q[16:0]})));
		end
		if (cmd.div_start) begin
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			if (cnt_q == 6'd0) begin
				rem_q <= '0;
				quo_q <= (total_q <= 0) ? 50'd0 : 50'(total_q);
				cnt_q <= 6'd1;
			end else begin
				cnt_q <= cnt_q + 6'd1;
				if (!trial[50]) begin
					rem_q <= trial[49:0];
					quo_q <= {quo_q[48:0], 1'b1};
				end else begin
					rem_q <= {rem_q[48:0], quo_q[49]};
					quo_q <= {quo_q[48:0], 1'b0};
				end
			end
		end
		if (cmd.seg_take)
			rate_q <= (total_q <= 0) ? 16'd0
				: (|quo_q[49:16]) ? 16'hFFFF : quo_q[15:0];
		if (cmd.edge_read) begin
			if (n == '0)
				rate_q <= '0;
			f_time_q <= (n == '0) ? 32'd0 : key_time_q[0];
			f_rate_q <= key_rate_q[0];
			e_time_q <= (n == '0) ? 32'hFFFF_FFFF : key_time_q[IDX_W'(n - 1'b1)];
			e_rate_q <= key_rate_q[IDX_W'(n - 1'b1)];
		end
		if (cmd.emit_mul) begin
			prod_q <= 33'((49'(held_rate_q) * 49'(req_q.delta_time)) >> 16);
		end
		if (cmd.out_load) begin
			if (sts.is_write)
				rsp_q.emit_count <= '0;
			else
				rsp_q.emit_count <= (|prod_q[32:16]) ? 16'hFFFF : prod_q[15:0];
			rsp_q.current_rate  <= held_rate_q;
			rsp_q.play_position <= play_time_q;
		end
	end

	assign emit_q = rsp_q.emit_count;
	assign rsp = {emit_q, rsp_q.current_rate, rsp_q.play_position};

	ap_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.read_seg |-> seg_q + 1'b1 < n) else $error("segment beyond table");
	ap_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step && cnt_q != 6'd0 |-> cnt_q <= 6'd51) else $error("divide overrun");
	ap_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_key |=> $stable(play_time_q)) else $error("write moved clock");
endmodule

### design/keyframe_rate_envelope_core.sv
// a write stores its keyframe; a tick advances the play clock and walks each segment,
// running the serial divider only for a matching segment whose time span is not zero
// throughput: one item at a time, set by the 50-step serial divider per segment
// reset: arst_n clears registers, play time and held rate; keyframes are undefined
// ----------------------------------------------------------------------------
// keyframe_rate_envelope_core
// Keyframe rate envelope: play clock, interpolated rate and emit count.
// ----------------------------------------------------------------------------
module keyframe_rate_envelope_core import kre_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	kre_if.sink           in_ch,
	kre_if.source         out_ch,
	kre_if.sink           cfg_ch
);
	cmd_t cmd;
	sts_t sts;

	assign cfg_ch.ready = 1'b1;

	kre_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	kre_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (in_ch.data),
		.cfg_we (cfg_ch.valid),
		.cfg    (cfg_ch.data),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (out_ch.data)
	);
endmodule
